// ===== rtl/ccs_pkg.sv =====
// Shared types and constants for the coherent cycle search block.
`default_nettype none
package ccs_pkg;

    localparam int unsigned MAX_SAMPLES = 65536;

    localparam int ACC_W  = 60;   // shared multiply/divide accumulator
    localparam int GOAL_W = 58;   // products c*rate and target*length
    localparam int REM_W  = 41;
    localparam int CNT_W  = 6;

    localparam logic [CNT_W-1:0] MUL_STEPS  = 6'd20;
    localparam logic [CNT_W-1:0] DIV_STEPS  = 6'd60;
    localparam logic [CNT_W-1:0] GCD_STEPS  = 6'd17;
    localparam logic [19:0]      PPM_SCALE  = 20'd1000000;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TOO_FEW = 2'd1,
        ST_RANGE   = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_GOAL_MUL,
        OP_GOAL_SAVE,
        OP_PROD_MUL,
        OP_PROD_SAVE,
        OP_GCD_INIT_C,
        OP_GCD_INIT_BEST,
        OP_GCD_DIV,
        OP_GCD_SHIFT,
        OP_DIST,
        OP_CMP,
        OP_NEXT,
        OP_COH_DIV,
        OP_COH_SAVE,
        OP_ERR,
        OP_PPM_MUL,
        OP_PPM_DIV,
        OP_OUT_OK,
        OP_OUT_FAIL
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t fail_status;
    } ccs_cmd_t;

    typedef struct packed {
        status_t pre_status;
        logic    busy;
        logic    gb_zero;
        logic    ga_one;
        logic    cop;
        logic    c_last;
        logic    found;
    } ccs_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ccs_datapath.sv =====
// Datapath: request registers, serial multiply/divide unit, search and result registers.
`default_nettype none
module ccs_datapath #(
    parameter int unsigned MAX_SAMPLES = ccs_pkg::MAX_SAMPLES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ccs_pkg::ccs_cmd_t  cmd,
    output ccs_pkg::ccs_stat_t      stat,
    input  wire logic [39:0]        target_freq,
    input  wire logic [39:0]        sample_rate,
    input  wire logic [16:0]        record_length,
    input  wire logic [16:0]        cycles_min,
    input  wire logic [16:0]        cycles_max,
    input  wire logic               need_coprime,
    output logic [1:0]              status,
    output logic [15:0]             chosen_cycles,
    output logic [16:0]             record_samples,
    output logic [16:0]             cycle_gcd,
    output logic [39:0]             coherent_freq,
    output logic signed [40:0]      freq_error,
    output logic [39:0]             abs_error,
    output logic signed [31:0]      error_ppm
);
    import ccs_pkg::*;

    logic [39:0]        tgt_reg, rate_reg;
    logic [16:0]        len_reg, c_reg, cmin_reg, cmax_reg;
    logic               cop_reg;
    logic [GOAL_W-1:0]  goal_reg, prod_reg, dist_reg, best_d_reg, best_prod_reg;
    logic [16:0]        best_reg;
    logic               found_reg;
    logic [16:0]        ga_reg, gb_reg;
    logic [39:0]        coh_reg, mag_reg;
    logic               neg_reg;

    // serial arithmetic unit
    logic [ACC_W-1:0]   acc_reg, mc_reg;
    logic [19:0]        mp_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [39:0]        dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               div_mode_reg;

    logic [REM_W-1:0]   rem_shift;
    logic               rem_ge;
    logic [GOAL_W-1:0]  dist_next;
    logic [31:0]        ppm_sat;

    status_t            pre;

    assign rem_shift = {rem_reg[REM_W-2:0], acc_reg[ACC_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, dvs_reg};
    assign dist_next = (prod_reg >= goal_reg) ? (prod_reg - goal_reg) : (goal_reg - prod_reg);

    always_comb
    begin
        if (neg_reg)
            ppm_sat = (acc_reg > ACC_W'(64'h80000000)) ? 32'h80000000
                                                       : (32'd0 - acc_reg[31:0]);
        else
            ppm_sat = (acc_reg > ACC_W'(64'h7FFFFFFF)) ? 32'h7FFFFFFF : acc_reg[31:0];
    end

    always_comb
    begin
        if (len_reg < 17'd2)
            pre = ST_TOO_FEW;
        else if (tgt_reg == 40'd0 || rate_reg == 40'd0 || {tgt_reg, 1'b0} >= {1'b0, rate_reg})
            pre = ST_RANGE;
        else if (cmin_reg == 17'd0 || cmin_reg > cmax_reg || cmax_reg > {1'b0, len_reg[16:1]}
                 || {8'd0, len_reg} > 25'(MAX_SAMPLES))
            pre = ST_RANGE;
        else
            pre = ST_OK;
    end

    assign stat.pre_status = pre;
    assign stat.busy       = cnt_reg != '0;
    assign stat.gb_zero    = gb_reg == 17'd0;
    assign stat.ga_one     = ga_reg == 17'd1;
    assign stat.cop        = cop_reg;
    assign stat.c_last     = c_reg == cmax_reg;
    assign stat.found      = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (div_mode_reg)
                begin
                    acc_reg <= {acc_reg[ACC_W-2:0], rem_ge};
                    rem_reg <= rem_ge ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
                end
                else
                begin
                    if (mp_reg[0])
                        acc_reg <= acc_reg + mc_reg;
                    mc_reg <= {mc_reg[ACC_W-2:0], 1'b0};
                    mp_reg <= {1'b0, mp_reg[19:1]};
                end
            end

            case (cmd.op)
                OP_LOAD:
                begin
                    tgt_reg   <= target_freq;
                    rate_reg  <= sample_rate;
                    len_reg   <= record_length;
                    cmin_reg  <= cycles_min;
                    cmax_reg  <= cycles_max;
                    c_reg     <= cycles_min;
                    cop_reg   <= need_coprime;
                    found_reg <= 1'b0;
                end
                OP_GOAL_MUL:
                begin
                    acc_reg      <= '0;
                    mc_reg       <= ACC_W'(tgt_reg);
                    mp_reg       <= 20'(len_reg);
                    cnt_reg      <= MUL_STEPS;
                    div_mode_reg <= 1'b0;
                end
                OP_GOAL_SAVE: goal_reg <= acc_reg[GOAL_W-1:0];
                OP_PROD_MUL:
                begin
                    acc_reg      <= '0;
                    mc_reg       <= ACC_W'(rate_reg);
                    mp_reg       <= 20'(c_reg);
                    cnt_reg      <= MUL_STEPS;
                    div_mode_reg <= 1'b0;
                end
                OP_PROD_SAVE: prod_reg <= acc_reg[GOAL_W-1:0];
                OP_GCD_INIT_C:
                begin
                    ga_reg <= c_reg;
                    gb_reg <= len_reg;
                end
                OP_GCD_INIT_BEST:
                begin
                    ga_reg <= best_reg;
                    gb_reg <= len_reg;
                end
                OP_GCD_DIV:
                begin
                    // dividend sits in the top bits so 17 steps suffice
                    acc_reg      <= {ga_reg, {(ACC_W-17){1'b0}}};
                    rem_reg      <= '0;
                    dvs_reg      <= 40'(gb_reg);
                    cnt_reg      <= GCD_STEPS;
                    div_mode_reg <= 1'b1;
                end
                OP_GCD_SHIFT:
                begin
                    ga_reg <= gb_reg;
                    gb_reg <= rem_reg[16:0];
                end
                OP_DIST: dist_reg <= dist_next;
                OP_CMP:
                begin
                    if (!found_reg || dist_reg < best_d_reg)
                    begin
                        found_reg     <= 1'b1;
                        best_d_reg    <= dist_reg;
                        best_reg      <= c_reg;
                        best_prod_reg <= prod_reg;
                    end
                end
                OP_NEXT:
                begin
                    c_reg    <= c_reg + 17'd1;
                    prod_reg <= prod_reg + GOAL_W'(rate_reg);
                end
                OP_COH_DIV:
                begin
                    acc_reg      <= ACC_W'(best_prod_reg);
                    rem_reg      <= '0;
                    dvs_reg      <= 40'(len_reg);
                    cnt_reg      <= DIV_STEPS;
                    div_mode_reg <= 1'b1;
                end
                OP_COH_SAVE: coh_reg <= acc_reg[39:0];
                OP_ERR:
                begin
                    neg_reg <= coh_reg < tgt_reg;
                    mag_reg <= (coh_reg < tgt_reg) ? (tgt_reg - coh_reg) : (coh_reg - tgt_reg);
                end
                OP_PPM_MUL:
                begin
                    acc_reg      <= '0;
                    mc_reg       <= ACC_W'(mag_reg);
                    mp_reg       <= PPM_SCALE;
                    cnt_reg      <= MUL_STEPS;
                    div_mode_reg <= 1'b0;
                end
                OP_PPM_DIV:
                begin
                    // product stays in the accumulator as the dividend
                    rem_reg      <= '0;
                    dvs_reg      <= tgt_reg;
                    cnt_reg      <= DIV_STEPS;
                    div_mode_reg <= 1'b1;
                end
                OP_OUT_OK:
                begin
                    status         <= ST_OK;
                    chosen_cycles  <= best_reg[15:0];
                    record_samples <= len_reg;
                    cycle_gcd      <= ga_reg;
                    coherent_freq  <= coh_reg;
                    freq_error     <= neg_reg ? (41'd0 - {1'b0, mag_reg}) : {1'b0, mag_reg};
                    abs_error      <= mag_reg;
                    error_ppm      <= ppm_sat;
                end
                OP_OUT_FAIL:
                begin
                    status         <= cmd.fail_status;
                    chosen_cycles  <= '0;
                    record_samples <= len_reg;
                    cycle_gcd      <= '0;
                    coherent_freq  <= '0;
                    freq_error     <= '0;
                    abs_error      <= '0;
                    error_ppm      <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ccs_ctrl.sv =====
// Controller state machine sequencing the search and the result calculation.
`default_nettype none
module ccs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ccs_pkg::ccs_cmd_t       cmd,
    input  wire ccs_pkg::ccs_stat_t stat
);
    import ccs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_GOAL_W, S_PROD, S_PROD_W, S_TEST, S_GCD_CHK, S_GCD_W,
        S_DIST, S_CMP, S_NEXT_CHK, S_FGCD, S_FG_CHK, S_FG_W, S_COH_W, S_ERR,
        S_PMUL, S_PMUL_W, S_PDIV, S_PDIV_W, S_DONE, S_FAIL
    } state_t;

    state_t  state_reg, state_next;
    status_t fail_reg, fail_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        fail_next       = fail_reg;
        out_valid_next  = out_valid_reg && out_stall;
        cmd.op          = OP_NONE;
        cmd.fail_status = fail_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            S_CHECK:
                if (stat.pre_status != ST_OK)
                begin
                    fail_next  = stat.pre_status;
                    state_next = S_FAIL;
                end
                else
                begin
                    cmd.op     = OP_GOAL_MUL;
                    state_next = S_GOAL_W;
                end
            S_GOAL_W:
                if (!stat.busy)
                begin
                    cmd.op     = OP_GOAL_SAVE;
                    state_next = S_PROD;
                end
            S_PROD:
            begin
                cmd.op     = OP_PROD_MUL;
                state_next = S_PROD_W;
            end
            S_PROD_W:
                if (!stat.busy)
                begin
                    cmd.op     = OP_PROD_SAVE;
                    state_next = S_TEST;
                end
            S_TEST:
                if (stat.cop)
                begin
                    cmd.op     = OP_GCD_INIT_C;
                    state_next = S_GCD_CHK;
                end
                else
                    state_next = S_DIST;
            S_GCD_CHK:
                if (stat.gb_zero)
                    state_next = stat.ga_one ? S_DIST : S_NEXT_CHK;
                else
                begin
                    cmd.op     = OP_GCD_DIV;
                    state_next = S_GCD_W;
                end
            S_GCD_W:
                if (!stat.busy)
                begin
                    cmd.op     = OP_GCD_SHIFT;
                    state_next = S_GCD_CHK;
                end
            S_DIST:
            begin
                cmd.op     = OP_DIST;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.op     = OP_CMP;
                state_next = S_NEXT_CHK;
            end
            S_NEXT_CHK:
                if (!stat.c_last)
                begin
                    cmd.op     = OP_NEXT;
                    state_next = S_TEST;
                end
                else if (stat.found)
                    state_next = S_FGCD;
                else
                begin
                    fail_next  = ST_NONE;
                    state_next = S_FAIL;
                end
            S_FGCD:
            begin
                cmd.op     = OP_GCD_INIT_BEST;
                state_next = S_FG_CHK;
            end
            S_FG_CHK:
                if (stat.gb_zero)
                begin
                    cmd.op     = OP_COH_DIV;
                    state_next = S_COH_W;
                end
                else
                begin
                    cmd.op     = OP_GCD_DIV;
                    state_next = S_FG_W;
                end
            S_FG_W:
                if (!stat.busy)
                begin
                    cmd.op     = OP_GCD_SHIFT;
                    state_next = S_FG_CHK;
                end
            S_COH_W:
                if (!stat.busy)
                begin
                    cmd.op     = OP_COH_SAVE;
                    state_next = S_ERR;
                end
            S_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                cmd.op     = OP_PPM_MUL;
                state_next = S_PMUL_W;
            end
            S_PMUL_W:
                if (!stat.busy)
                    state_next = S_PDIV;
            S_PDIV:
            begin
                cmd.op     = OP_PPM_DIV;
                state_next = S_PDIV_W;
            end
            S_PDIV_W:
                if (!stat.busy)
                    state_next = S_DONE;
            S_DONE:
                if (out_free)
                begin
                    cmd.op         = OP_OUT_OK;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            S_FAIL:
                if (out_free)
                begin
                    cmd.op         = OP_OUT_FAIL;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fail_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/coherent_cycle_search.sv =====
// Coherent cycle search: picks the cycle count per record nearest a target frequency.
// Input channel (in_valid/in_stall) takes one request word: target frequency and
// sample rate in Q32.8 Hz, record length, cycle range and a coprime flag.
// Output channel (out_valid/out_stall) returns one result word per request.
// Requests are handled one at a time; in_stall is high from acceptance until the
// result is loaded into the output register. The next request can then be taken
// while that result still waits on a stalled receiver.
// A rejected request goes straight from the range check to its fail result. Otherwise
// the goal product is formed, then each cycle count gets its product and, with the
// coprime flag set, a Euclid test against the record length; a kept count is
// compared by distance. Then follow the Euclid steps for the final GCD, the 60-step
// frequency division, the 20-step ppm multiply and the 60-step ppm division, all
// on the single bit-serial multiply/divide unit.
// Reset (rst_n low, asynchronous) returns the controller to idle and drops
// out_valid; a result held under out_stall keeps its payload stable.
`default_nettype none
module coherent_cycle_search #(
    parameter int unsigned MAX_SAMPLES = ccs_pkg::MAX_SAMPLES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [39:0]        target_freq,
    input  wire logic [39:0]        sample_rate,
    input  wire logic [16:0]        record_length,
    input  wire logic [16:0]        cycles_min,
    input  wire logic [16:0]        cycles_max,
    input  wire logic               need_coprime,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [15:0]             chosen_cycles,
    output logic [16:0]             record_samples,
    output logic [16:0]             cycle_gcd,
    output logic [39:0]             coherent_freq,
    output logic signed [40:0]      freq_error,
    output logic [39:0]             abs_error,
    output logic signed [31:0]      error_ppm
);
    import ccs_pkg::*;

    ccs_cmd_t  cmd;
    ccs_stat_t stat;

    ccs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    ccs_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .target_freq    (target_freq),
        .sample_rate    (sample_rate),
        .record_length  (record_length),
        .cycles_min     (cycles_min),
        .cycles_max     (cycles_max),
        .need_coprime   (need_coprime),
        .status         (status),
        .chosen_cycles  (chosen_cycles),
        .record_samples (record_samples),
        .cycle_gcd      (cycle_gcd),
        .coherent_freq  (coherent_freq),
        .freq_error     (freq_error),
        .abs_error      (abs_error),
        .error_ppm      (error_ppm)
    );

endmodule
`default_nettype wire

// ===== rtl/ccs_checker.sv =====
// Port-level checker for the coherent cycle search block, with its bind.
`default_nettype none
module ccs_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [1:0]         status,
    input  wire logic [15:0]        chosen_cycles,
    input  wire logic [39:0]        coherent_freq,
    input  wire logic signed [40:0] freq_error,
    input  wire logic [39:0]        abs_error
);
    import ccs_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(chosen_cycles))
        else $error("result word changed under stall");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> chosen_cycles == 16'd0 && coherent_freq == 40'd0
            && abs_error == 40'd0)
        else $error("failed request carries nonzero result");

    a_ok_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> chosen_cycles != 16'd0
            && (freq_error[40] ? (41'd0 - freq_error) == {1'b0, abs_error}
                               : freq_error == {1'b0, abs_error}))
        else $error("error magnitude does not match signed error");

endmodule

bind coherent_cycle_search ccs_checker u_ccs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .chosen_cycles (chosen_cycles),
    .coherent_freq (coherent_freq),
    .freq_error    (freq_error),
    .abs_error     (abs_error)
);
`default_nettype wire

// ===== tb/sv/tb_coherent_cycle_search.sv =====
// Self-checking testbench for coherent_cycle_search with a scoreboard and random idling.
`default_nettype none
module tb_coherent_cycle_search;
    timeunit 1ns;
    timeprecision 1ps;
    import ccs_pkg::*;

    typedef struct {
        logic [39:0] tgt;
        logic [39:0] rate;
        logic [16:0] len;
        logic [16:0] cmin;
        logic [16:0] cmax;
        logic        cop;
    } req_t;

    typedef struct {
        status_t            st;
        logic [15:0]        best;
        logic [16:0]        rec;
        logic [16:0]        g;
        logic [39:0]        coh;
        logic signed [40:0] err;
        logic [39:0]        aerr;
        logic signed [31:0] ppm;
    } res_t;

    class cycle_search_board;
        res_t pending_q[$];
        int   errors = 0;

        function automatic logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
            logic [63:0] r;
            while (b != 0)
            begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        function automatic res_t search(req_t r);
            res_t        e;
            logic [63:0] goal, d, bd, c, prod, mag, q, coh;
            logic        found, neg;
            e = '{st: ST_OK, best: 0, rec: r.len, g: 0, coh: 0, err: 0, aerr: 0, ppm: 0};
            found = 0;
            bd = 0;
            if (r.len < 2)
                e.st = ST_TOO_FEW;
            else if (r.tgt == 0 || r.rate == 0 || 64'(r.tgt) * 2 >= 64'(r.rate))
                e.st = ST_RANGE;
            else if (r.cmin == 0 || r.cmin > r.cmax || r.cmax > r.len / 2
                     || r.len > MAX_SAMPLES)
                e.st = ST_RANGE;
            else
            begin
                goal = 64'(r.tgt) * 64'(r.len);
                for (c = 64'(r.cmin); c <= 64'(r.cmax); c++)
                begin
                    if (r.cop && euclid(c, 64'(r.len)) != 1)
                        continue;
                    prod = c * 64'(r.rate);
                    d = (prod >= goal) ? prod - goal : goal - prod;
                    if (!found || d < bd)
                    begin
                        found = 1;
                        bd = d;
                        e.best = c[15:0];
                    end
                end
                if (!found)
                begin
                    e.st = ST_NONE;
                    e.best = 0;
                end
                else
                begin
                    e.g = 17'(euclid(64'(e.best), 64'(r.len)));
                    coh = (64'(e.best) * 64'(r.rate)) / 64'(r.len);
                    e.coh = coh[39:0];
                    neg = coh < 64'(r.tgt);
                    mag = neg ? 64'(r.tgt) - coh : coh - 64'(r.tgt);
                    e.aerr = mag[39:0];
                    e.err = neg ? -$signed({1'b0, mag[39:0]}) : $signed({1'b0, mag[39:0]});
                    q = (mag * 64'd1000000) / 64'(r.tgt);
                    if (neg)
                        e.ppm = (q > 64'h80000000) ? 32'sh80000000 : -$signed(q[31:0]);
                    else
                        e.ppm = (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(q[31:0]);
                end
            end
            return e;
        endfunction

        function void note_request(req_t r);
            pending_q.push_back(search(r));
        endfunction

        function void check_result(res_t a);
            res_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result word, status %0d", $time, a.st);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (a.st !== e.st)
                mism("status", 64'(e.st), 64'(a.st));
            if (a.best !== e.best)
                mism("chosen_cycles", 64'(e.best), 64'(a.best));
            if (a.rec !== e.rec)
                mism("record_samples", 64'(e.rec), 64'(a.rec));
            if (a.g !== e.g)
                mism("cycle_gcd", 64'(e.g), 64'(a.g));
            if (a.coh !== e.coh)
                mism("coherent_freq", 64'(e.coh), 64'(a.coh));
            if (a.err !== e.err)
                mism("freq_error", 64'(e.err), 64'(a.err));
            if (a.aerr !== e.aerr)
                mism("abs_error", 64'(e.aerr), 64'(a.aerr));
            if (a.ppm !== e.ppm)
                mism("error_ppm", 64'(e.ppm), 64'(a.ppm));
        endfunction

        function void mism(string f, logic [63:0] e, logic [63:0] a);
            $display("%0t: %s mismatch, expected %h actual %h", $time, f, e, a);
            errors++;
        endfunction
    endclass

    logic               clk, rst_n;
    logic               in_valid, in_stall, out_valid, out_stall;
    logic [39:0]        target_freq, sample_rate;
    logic [16:0]        record_length, cycles_min, cycles_max;
    logic               need_coprime;
    logic [1:0]         status;
    logic [15:0]        chosen_cycles;
    logic [16:0]        record_samples, cycle_gcd;
    logic [39:0]        coherent_freq, abs_error;
    logic signed [40:0] freq_error;
    logic signed [31:0] error_ppm;

    int snd_idle = 28;
    int rcv_idle = 85;
    cycle_search_board board = new();

    coherent_cycle_search DUT (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #500ms;
        $display("coherent_cycle_search verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result('{st: status_t'(status), best: chosen_cycles,
                rec: record_samples, g: cycle_gcd, coh: coherent_freq,
                err: freq_error, aerr: abs_error, ppm: error_ppm});
        out_stall <= ($urandom_range(99) < rcv_idle);
    end

    task automatic send_request(req_t r);
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid      <= 1;
        target_freq   <= r.tgt;
        sample_rate   <= r.rate;
        record_length <= r.len;
        cycles_min    <= r.cmin;
        cycles_max    <= r.cmax;
        need_coprime  <= r.cop;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(r);
    endtask

    function automatic req_t mk(logic [39:0] t, logic [39:0] s, logic [16:0] l,
                                logic [16:0] a, logic [16:0] b, logic c);
        return '{tgt: t, rate: s, len: l, cmin: a, cmax: b, cop: c};
    endfunction

    // mostly well-formed requests with short spans; the rest raw noise
    function automatic req_t random_request();
        req_t        r;
        logic [16:0] half;
        int          span;
        r.rate = 40'({$urandom(), $urandom()});
        r.cop  = 1'($urandom_range(1));
        if ($urandom_range(99) < 70)
        begin
            if (r.rate < 4)
                r.rate = 40'd4 + 40'($urandom_range(1000));
            r.tgt = 40'(64'd1 + (64'({$urandom(), $urandom()})
                                 % 64'((r.rate - 40'd1) / 40'd2)));
            case ($urandom_range(9))
                0: r.len = 17'd65536;
                1: r.len = 17'($urandom_range(65536, 2));
                default: r.len = 17'($urandom_range(4096, 2));
            endcase
            half   = r.len / 17'd2;
            r.cmin = 17'($urandom_range(half, 1));
            span   = ($urandom_range(19) == 0) ? 300 : 40;
            r.cmax = 17'(r.cmin + $urandom_range(span));
            if (r.cmax > half)
                r.cmax = half;
        end
        else
        begin
            r.tgt  = 40'({$urandom(), $urandom()});
            r.len  = 17'($urandom());
            r.cmin = 17'($urandom());
            r.cmax = 17'($urandom());
            if (r.cmax > r.cmin + 40)
                r.cmax = 17'(r.cmin + 40);
        end
        return r;
    endfunction

    initial
    begin
        req_t dir_q[$];
        in_valid = 0;
        target_freq = 0;
        sample_rate = 0;
        record_length = 0;
        cycles_min = 0;
        cycles_max = 0;
        need_coprime = 0;
        rst_n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        dir_q = '{
            mk(40'd1000, 40'd48000, 17'd0, 17'd1, 17'd1, 1'b0),
            mk(40'd1000, 40'd48000, 17'd1, 17'd1, 17'd1, 1'b0),
            mk(40'd0, 40'd48000, 17'd64, 17'd1, 17'd4, 1'b0),
            mk(40'd1000, 40'd0, 17'd64, 17'd1, 17'd4, 1'b0),
            mk(40'd24000, 40'd48000, 17'd64, 17'd1, 17'd4, 1'b0),
            mk(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b1),
            mk(40'd1000, 40'd48000, 17'd64, 17'd0, 17'd4, 1'b0),
            mk(40'd1000, 40'd48000, 17'd64, 17'd5, 17'd4, 1'b0),
            mk(40'd1000, 40'd48000, 17'd64, 17'd1, 17'd33, 1'b0),
            mk(40'd1000, 40'd48000, 17'd65537, 17'd1, 17'd4, 1'b0),
            mk(40'd1000, 40'd48000, 17'd4, 17'd2, 17'd2, 1'b1),
            mk(40'd1, 40'd4, 17'd6, 17'd1, 17'd2, 1'b0),
            mk(40'd1, 40'd3, 17'd4, 17'd1, 17'd1, 1'b0),
            mk(40'd1, 40'hFF_FFFF_FFFF, 17'd4, 17'd2, 17'd2, 1'b0),
            mk(40'h7F_FFFF_FFFF, 40'hFF_FFFF_FFFF, 17'd65536, 17'd32768, 17'd32768, 1'b0),
            mk(40'h7F_FFFF_FFFE, 40'hFF_FFFF_FFFF, 17'd65536, 17'd32730, 17'd32768, 1'b1),
            mk(40'd256000, 40'd12288000, 17'd2, 17'd1, 17'd1, 1'b1),
            mk(40'd300000, 40'd12288000, 17'd1024, 17'd1, 17'd40, 1'b1),
            mk(40'd300000, 40'd12288000, 17'd1000, 17'd20, 17'd60, 1'b0)
        };
        foreach (dir_q[i])
            send_request(dir_q[i]);

        for (int k = 0; k < 81; k++)
        begin
            if (k == 14)
            begin
                snd_idle = 85;
                rcv_idle = 28;
            end
            else if (k == 47)
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            send_request(random_request());
        end
        in_valid <= 0;

        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("coherent_cycle_search verification clean");
        else
            $display("coherent_cycle_search verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/ccs_pkg.sv
rtl/ccs_datapath.sv
rtl/ccs_ctrl.sv
rtl/coherent_cycle_search.sv
rtl/ccs_checker.sv
tb/sv/tb_coherent_cycle_search.sv
